// ===== sv/pfa_pkg.sv =====
package pfa_pkg;
  localparam int SLOT_PAGES = 64;
  localparam int PAGE_W = 6;
  localparam int COUNT_W = 7;

  localparam logic [1:0] OP_CREATE    = 2'd0;
  localparam logic [1:0] OP_RESIZE    = 2'd1;
  localparam logic [1:0] OP_TRANSLATE = 2'd2;
  localparam logic [1:0] OP_DELETE    = 2'd3;

  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_SHORT   = 3'd1;
  localparam logic [2:0] ST_NO_PID  = 3'd2;
  localparam logic [2:0] ST_UNMAP   = 3'd3;
  localparam logic [2:0] ST_NO_SLOT = 3'd4;

  localparam logic [0:0] REG_PAGE_BYTES = 1'd0;
  localparam logic [0:0] REG_FRAMES     = 1'd1;

  typedef struct packed {
    logic       start;
    logic [31:0] dividend;
    logic [16:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [32:0] quot;
  } div_rsp_t;
endpackage

// ===== sv/pfa_ram.sv =====
module pfa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// ===== sv/pfa_div.sv =====
module pfa_div (
  input  logic              clk,
  input  logic              rst_n,
  input  pfa_pkg::div_req_t req,
  output pfa_pkg::div_rsp_t rsp
);
  import pfa_pkg::*;

  logic [32:0] num_r, num_nxt;
  logic [16:0] den_r, den_nxt;
  logic [17:0] rem_r, rem_nxt;
  logic [5:0]  cnt_r, cnt_nxt;
  logic        busy_r, busy_nxt;
  logic        done_r, done_nxt;
  logic [17:0] trial;

  // restoring division of (bytes + div - 1) by div, one quotient bit a cycle
  always_comb begin
    num_nxt  = num_r;
    den_nxt  = den_r;
    rem_nxt  = rem_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    trial    = {rem_r[16:0], num_r[32]};
    if (req.start) begin
      den_nxt  = (req.divisor == 17'd0) ? 17'd1 : req.divisor;
      num_nxt  = {1'b0, req.dividend} + {16'd0, den_nxt} - 33'd1;
      rem_nxt  = '0;
      cnt_nxt  = 6'd33;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (trial >= {1'b0, den_r}) begin
        rem_nxt = trial - {1'b0, den_r};
        num_nxt = {num_r[31:0], 1'b1};
      end else begin
        rem_nxt = trial;
        num_nxt = {num_r[31:0], 1'b0};
      end
      cnt_nxt = cnt_r - 6'd1;
      if (cnt_r == 6'd1) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    num_r <= num_nxt;
    den_r <= den_nxt;
    rem_r <= rem_nxt;
    cnt_r <= cnt_nxt;
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  assign rsp.done = done_r;
  assign rsp.quot = num_r;
endmodule

// ===== sv/paged_frame_allocator_top.sv =====
// Flow from accept to out_valid: slot search, then dispatch, which ends create, unknown pid and
//   unmapped page; a mapped translate adds a map RAM read. Slot search checks one slot a cycle.
// Resize: rejected after the 33-step serial divider, else grows by scanning n frames
//   (n <= NUM_FRAMES) or shrinks by freeing p pages; delete frees every page of the slot.
// Throughput: one item at a time; in_stall is high from acceptance until the result is taken.
// Reset (rst_n low, synchronous): frame bitmap, slot valid bits, page counts, config registers,
//   state and out_valid return to reset values at once; no clearing pass.
module paged_frame_allocator_top #(
  parameter int NUM_FRAMES = 64,
  parameter int MAX_PROCS  = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_operation,
  input  logic [31:0] in_process_id,
  input  logic [31:0] in_byte_count,
  input  logic [5:0]  in_page_number,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  out_status,
  output logic [5:0]  out_frame_number,
  output logic [6:0]  out_pages_short,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);
  import pfa_pkg::*;

  localparam int SW = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;
  localparam int FW = $clog2(NUM_FRAMES);
  localparam int AW = SW + PAGE_W;
  localparam int CAP = (NUM_FRAMES < SLOT_PAGES) ? NUM_FRAMES : SLOT_PAGES;

  typedef enum logic [8:0] {
    S_IDLE   = 9'b000000001,
    S_SEARCH = 9'b000000010,
    S_DISP   = 9'b000000100,
    S_DIV    = 9'b000001000,
    S_GROW   = 9'b000010000,
    S_SHRINK = 9'b000100000,
    S_RD     = 9'b001000000,
    S_FREE   = 9'b010000000,
    S_OUT    = 9'b100000000
  } state_t;

  state_t state_r, state_nxt;

  logic [16:0] page_bytes_r;
  logic [6:0]  frames_r;
  logic [NUM_FRAMES-1:0] frame_used_r;
  logic [MAX_PROCS-1:0]  slot_valid_r;
  logic [31:0] slot_owner_r [MAX_PROCS];
  logic [6:0]  slot_count_r [MAX_PROCS];

  logic [1:0]  op_r;
  logic [31:0] pid_r, bytes_r;
  logic [5:0]  page_r;
  logic [SW:0] idx_r;
  logic        hit_r, free_ok_r;
  logic [SW-1:0] hit_slot_r, free_slot_r;
  logic [6:0]  have_r, want_r, limit_r;
  logic [FW:0] f_r;
  logic [2:0]  status_r;
  logic [5:0]  frame_r;
  logic [6:0]  short_r;
  logic        rd_wait_r;

  div_req_t dreq;
  div_rsp_t drsp;

  logic          ram_we;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [5:0]    ram_wdata, ram_rdata;

  logic cfg_wr;
  assign cfg_wr = cfg_psel & cfg_penable & cfg_pwrite;
  assign cfg_pready = 1'b1;

  always_comb begin
    unique case (cfg_paddr[2])
      REG_PAGE_BYTES: cfg_prdata = {15'd0, page_bytes_r};
      default:        cfg_prdata = {25'd0, frames_r};
    endcase
  end

  pfa_div u_div (.clk(clk), .rst_n(rst_n), .req(dreq), .rsp(drsp));

  pfa_ram #(.WIDTH(PAGE_W), .DEPTH((2 ** SW) * SLOT_PAGES)) u_map (
    .clk(clk), .we(ram_we), .waddr(ram_waddr), .wdata(ram_wdata),
    .raddr(ram_raddr), .rdata(ram_rdata)
  );

  logic [SW-1:0] cur_slot;
  logic [6:0]    fu_lim;
  logic          f_free;
  assign cur_slot = idx_r[SW-1:0];
  assign fu_lim = (frames_r > 7'(CAP)) ? 7'(CAP) : frames_r;
  assign f_free = !frame_used_r[f_r[FW-1:0]];

  always_comb begin
    dreq.start    = (state_r == S_DISP) && hit_r && (op_r == OP_RESIZE);
    dreq.dividend = bytes_r;
    dreq.divisor  = page_bytes_r;
    ram_we    = (state_r == S_GROW) && (have_r != want_r) && (f_r < (FW+1)'(limit_r))
                && (f_r < (FW+1)'(NUM_FRAMES)) && f_free;
    ram_waddr = {hit_slot_r, have_r[5:0]};
    ram_wdata = 6'(f_r);
    ram_raddr = {hit_slot_r, (state_r == S_RD) ? page_r : (have_r[5:0] - 6'd1)};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      page_bytes_r <= 17'd32;
      frames_r     <= 7'd64;
      frame_used_r <= '0;
      slot_valid_r <= '0;
      out_valid    <= 1'b0;
      for (int i = 0; i < MAX_PROCS; i++) slot_count_r[i] <= '0;
    end else begin
      if (cfg_wr) begin
        unique case (cfg_paddr[2])
          REG_PAGE_BYTES: page_bytes_r <= cfg_pwdata[16:0];
          default:        frames_r     <= cfg_pwdata[6:0];
        endcase
      end
      unique case (state_r)
        S_IDLE: if (in_valid) begin
          op_r <= in_operation; pid_r <= in_process_id;
          bytes_r <= in_byte_count; page_r <= in_page_number;
          idx_r <= '0; hit_r <= 1'b0; free_ok_r <= 1'b0;
          status_r <= ST_OK; frame_r <= '0; short_r <= '0;
          state_r <= S_SEARCH;
        end
        S_SEARCH: begin
          // one slot compare per cycle
          if (slot_valid_r[cur_slot] && slot_owner_r[cur_slot] == pid_r && !hit_r) begin
            hit_r <= 1'b1; hit_slot_r <= cur_slot;
          end
          if (!slot_valid_r[cur_slot] && !free_ok_r) begin
            free_ok_r <= 1'b1; free_slot_r <= cur_slot;
          end
          if (idx_r == (SW+1)'(MAX_PROCS - 1)) state_r <= S_DISP;
          idx_r <= idx_r + 1'b1;
        end
        S_DISP: begin
          have_r  <= slot_count_r[hit_slot_r];
          limit_r <= fu_lim;
          f_r     <= '0;
          rd_wait_r <= 1'b0;
          state_r <= S_OUT;
          if (op_r == OP_CREATE) begin
            if (!hit_r) begin
              if (free_ok_r) begin
                slot_valid_r[free_slot_r] <= 1'b1;
                slot_owner_r[free_slot_r] <= pid_r;
                slot_count_r[free_slot_r] <= '0;
              end else status_r <= ST_NO_SLOT;
            end
          end else if (!hit_r) status_r <= ST_NO_PID;
          else if (op_r == OP_RESIZE) state_r <= S_DIV;
          else if (op_r == OP_TRANSLATE) begin
            if ({1'b0, page_r} >= slot_count_r[hit_slot_r]) status_r <= ST_UNMAP;
            else state_r <= S_RD;
          end else begin
            want_r <= '0;
            state_r <= S_FREE;
          end
        end
        S_DIV: if (drsp.done) begin
          if (drsp.quot > {26'd0, limit_r}) begin
            status_r <= ST_SHORT; state_r <= S_OUT;
          end else begin
            want_r <= drsp.quot[6:0];
            state_r <= (drsp.quot[6:0] > have_r) ? S_GROW : S_FREE;
          end
        end
        S_GROW: begin
          if (have_r == want_r || f_r >= (FW+1)'(limit_r)
              || f_r >= (FW+1)'(NUM_FRAMES)) begin
            slot_count_r[hit_slot_r] <= have_r;
            if (have_r != want_r) begin
              status_r <= ST_SHORT; short_r <= want_r - have_r;
            end
            state_r <= S_OUT;
          end else begin
            if (f_free) begin
              frame_used_r[f_r[FW-1:0]] <= 1'b1;
              have_r <= have_r + 7'd1;
            end
            f_r <= f_r + 1'b1;
          end
        end
        S_FREE: begin
          // read last page, then drop its frame on the next cycle
          if (have_r == want_r && !rd_wait_r) begin
            slot_count_r[hit_slot_r] <= have_r;
            if (op_r == OP_DELETE) slot_valid_r[hit_slot_r] <= 1'b0;
            state_r <= S_OUT;
          end else if (!rd_wait_r) rd_wait_r <= 1'b1;
          else begin
            rd_wait_r <= 1'b0;
            if ({26'd0, ram_rdata} < 32'(NUM_FRAMES))
              frame_used_r[FW'(ram_rdata)] <= 1'b0;
            have_r <= have_r - 7'd1;
          end
        end
        S_SHRINK: state_r <= S_FREE;
        S_RD: begin
          rd_wait_r <= 1'b1;
          if (rd_wait_r) begin frame_r <= ram_rdata; state_r <= S_OUT; end
        end
        S_OUT: begin
          if (!out_valid) out_valid <= 1'b1;
          else if (!out_stall) begin out_valid <= 1'b0; state_r <= S_IDLE; end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign in_stall = (state_r != S_IDLE);
  assign out_status = status_r;
  assign out_frame_number = frame_r;
  assign out_pages_short = short_r;
endmodule

// ===== sv/pfa_checker.sv =====
module pfa_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_stall,
  input logic       out_valid,
  input logic       out_stall,
  input logic [2:0] out_status,
  input logic [5:0] out_frame_number,
  input logic [6:0] out_pages_short
);
  import pfa_pkg::*;

  a_no_accept_while_out: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> in_stall) else $error("input taken while result pending");
  a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_status <= ST_NO_SLOT)) else $error("bad status");
  a_frame_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != ST_OK |-> out_frame_number == 6'd0)
    else $error("frame on failure");
  a_short_only: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_pages_short != 7'd0 |-> out_status == ST_SHORT)
    else $error("short without status");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_status))
    else $error("result dropped");
endmodule

bind paged_frame_allocator_top pfa_checker u_chk (.*);
